// File: rtl/core/sro_pkg.sv
// Shared types, codes and sizes for the sequence reorder buffer.
package sro_pkg;

   localparam int WINDOW_DEFAULT = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam int TAG_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int LENGTH_W  = 16;
   localparam int KIND_W    = 2;
   localparam int ENTRY_W   = PAYLOAD_W + LENGTH_W;

   // request kinds
   localparam logic REQ_ISSUE    = 1'b0;
   localparam logic REQ_COMPLETE = 1'b1;

   // response kinds
   localparam logic [KIND_W-1:0] RSP_GRANT   = 2'd0;
   localparam logic [KIND_W-1:0] RSP_DELIVER = 2'd1;
   localparam logic [KIND_W-1:0] RSP_RANGE   = 2'd2;

   typedef struct packed {
      logic                 kind;
      logic [TAG_W-1:0]     tag;
      logic [PAYLOAD_W-1:0] payload;
      logic [LENGTH_W-1:0]  length;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]    out_kind;
      logic [TAG_W-1:0]     tag_res;
      logic [PAYLOAD_W-1:0] payload_res;
      logic [LENGTH_W-1:0]  length_res;
      logic                 last;
   } rsp_word_type;

endpackage

// File: rtl/core/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: suspend register, front end and back end.
//
//  channel  ports                                  direction  flow control
//  request  start, busy, req_word                  in         accepted on start && !busy
//  result   rsp_strobe, rsp_word                   out        one-cycle strobe, no stall
//  config   csr_write_enable, csr_write_data       in         written on enable
//
// A tag issue, an out-of-window tag or a slot store passes the back end's IDLE and DECODE
// states. An in-order completion does too, then stays in DRAIN for each buffered word, one
// slot RAM read per cycle. The 2-entry request queue raises busy when full.
// Reset clears tag counters, slot valid bits, the queue and suspend; slot RAM is not cleared.
// The receiver cannot stall: rsp_strobe marks each result word on rsp_word for a single cycle.
module sequence_reorder_buffer #(
   parameter int WINDOW = sro_pkg::WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sro_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output sro_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   logic                  suspend_ff, suspend_in;
   logic                  head_valid;
   sro_pkg::req_word_type head;
   logic                  pop;

   assign suspend_in = csr_write_enable ? csr_write_data : suspend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         suspend_ff <= 1'b0;
      end else begin
         suspend_ff <= suspend_in;
      end
   end

   sro_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   sro_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .suspend    (suspend_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// File: rtl/core/sro_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sro_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sro_front.sv
// Front end: request acceptance, zero-length filtering and the request queue.
module sro_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sro_pkg::req_word_type req_word,
   output logic                  head_valid,
   output sro_pkg::req_word_type head,
   input  logic                  pop
);

   localparam int PTR_W = $clog2(sro_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sro_pkg::QUEUE_DEPTH + 1);

   sro_pkg::req_word_type entry_ff [sro_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             push;
   logic             do_pop;

   assign busy       = (count_ff == CNT_W'(sro_pkg::QUEUE_DEPTH));
   assign accept     = start && !busy;
   assign push       = accept && !(req_word.kind == sro_pkg::REQ_COMPLETE &&
                                   req_word.length == '0);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(sro_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

// File: rtl/core/sro_back.sv
// Back end: tag issue, window check, slot store and in-order drain.
module sro_back #(
   parameter int WINDOW = sro_pkg::WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  suspend,
   input  logic                  head_valid,
   input  sro_pkg::req_word_type head,
   output logic                  pop,
   output logic                  rsp_strobe,
   output sro_pkg::rsp_word_type rsp_word
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int TAG_W  = sro_pkg::TAG_W;
   localparam logic [SLOT_W:0] WIN_WIDE = (SLOT_W + 1)'(WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_DRAIN  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   sro_pkg::req_word_type op_ff, op_in;
   logic                  win_ff, win_in;
   logic                  zero_ff, zero_in;
   logic                  wrap_ff, wrap_in;
   logic [SLOT_W-1:0]     dist_ff, dist_in;
   logic [TAG_W-1:0]      ne_ff, ne_in;
   logic [SLOT_W-1:0]     ne_slot_ff, ne_slot_in;
   logic [TAG_W-1:0]      issue_ff, issue_in;
   logic [WINDOW-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   sro_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [TAG_W-1:0]             dist_full;
   logic [SLOT_W:0]              slot_sum;
   logic [SLOT_W-1:0]            store_slot;
   logic [SLOT_W-1:0]            nslot;
   logic                         next_valid;
   logic                         emit;
   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [SLOT_W-1:0]            ram_rd_addr;
   logic [sro_pkg::ENTRY_W-1:0]  ram_rd_data;

   sro_ram #(
      .WIDTH (sro_pkg::ENTRY_W),
      .DEPTH (WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (store_slot),
      .wr_data ({op_ff.payload, op_ff.length}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign dist_full = head.tag - ne_ff;
   assign slot_sum  = {1'b0, ne_slot_ff} + {1'b0, dist_ff};

   always_comb begin
      if (wrap_ff) begin
         store_slot = op_ff.tag[SLOT_W-1:0];
      end else if (slot_sum >= WIN_WIDE) begin
         store_slot = SLOT_W'(slot_sum - WIN_WIDE);
      end else begin
         store_slot = slot_sum[SLOT_W-1:0];
      end
   end

   // slot of next_expected + 1, restarting at zero past the window end or on a tag counter wrap
   always_comb begin
      if (&ne_ff) begin
         nslot = '0;
      end else if (ne_slot_ff == SLOT_W'(WINDOW - 1)) begin
         nslot = '0;
      end else begin
         nslot = ne_slot_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      win_in        = win_ff;
      zero_in       = zero_ff;
      wrap_in       = wrap_ff;
      dist_in       = dist_ff;
      ne_in         = ne_ff;
      ne_slot_in    = ne_slot_ff;
      issue_in      = issue_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = nslot;
      next_valid    = 1'b0;
      emit          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               op_in    = head;
               win_in   = (dist_full < TAG_W'(WINDOW));
               zero_in  = (dist_full == '0);
               wrap_in  = (head.tag < ne_ff);
               dist_in  = dist_full[SLOT_W-1:0];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (op_ff.kind == sro_pkg::REQ_ISSUE) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{out_kind: sro_pkg::RSP_GRANT, tag_res: issue_ff,
                                 payload_res: '0, length_res: '0, last: 1'b1};
               issue_in      = issue_ff + TAG_W'(1);
            end else if (!win_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{out_kind: sro_pkg::RSP_RANGE, tag_res: op_ff.tag,
                                 payload_res: '0, length_res: '0, last: 1'b1};
            end else if (!zero_ff) begin
               ram_wr_en            = 1'b1;
               valid_in[store_slot] = 1'b1;
            end else begin
               next_valid    = valid_ff[nslot];
               rsp_strobe_in = !suspend;
               rsp_word_in   = '{out_kind: sro_pkg::RSP_DELIVER, tag_res: op_ff.tag,
                                 payload_res: op_ff.payload, length_res: op_ff.length,
                                 last: !next_valid};
               cnt_in        = suspend ? '0 : CNT_W'(1);
               ne_in         = ne_ff + TAG_W'(1);
               ne_slot_in    = nslot;
               if (next_valid) begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            next_valid    = valid_ff[nslot] && (nslot != ne_slot_ff);
            emit          = !suspend && (cnt_ff < CNT_W'(WINDOW));
            rsp_strobe_in = emit;
            rsp_word_in   = '{out_kind: sro_pkg::RSP_DELIVER, tag_res: ne_ff,
                              payload_res: ram_rd_data[sro_pkg::ENTRY_W-1:sro_pkg::LENGTH_W],
                              length_res: ram_rd_data[sro_pkg::LENGTH_W-1:0],
                              last: !next_valid || (cnt_ff == CNT_W'(WINDOW - 1))};
            if (emit) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            valid_in[ne_slot_ff] = 1'b0;
            ne_in                = ne_ff + TAG_W'(1);
            ne_slot_in           = nslot;
            if (next_valid) begin
               ram_rd_en = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ne_ff         <= '0;
         ne_slot_ff    <= '0;
         issue_ff      <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ne_ff         <= ne_in;
         ne_slot_ff    <= ne_slot_in;
         issue_ff      <= issue_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      win_ff      <= win_in;
      zero_ff     <= zero_in;
      wrap_ff     <= wrap_in;
      dist_ff     <= dist_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// File: test/tb_top.sv
// Testbench for sequence_reorder_buffer: random and directed tag traffic checked by a scoreboard.
module tb_top;
   import sro_pkg::*;

   localparam int unsigned WIN = WINDOW_DEFAULT;
   localparam int DRAIN_CYCLES = 48;

   class delivery_scoreboard;
      bit                   suspend_mode = 1'b0;
      logic [TAG_W-1:0]     next_expected = '0;
      logic [TAG_W-1:0]     next_issue = '0;
      bit                   slot_valid[WIN];
      logic [PAYLOAD_W-1:0] slot_payload[WIN];
      logic [LENGTH_W-1:0]  slot_length[WIN];
      rsp_word_type         expected_words[$];
      int                   failures = 0;

      function void add_word(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                             logic [PAYLOAD_W-1:0] pay, logic [LENGTH_W-1:0] len);
         rsp_word_type r;
         r.out_kind    = kind;
         r.tag_res     = tag;
         r.payload_res = pay;
         r.length_res  = len;
         r.last        = 1'b0;
         expected_words.push_back(r);
      endfunction

      function void accept_request(req_word_type w);
         logic [TAG_W-1:0] tag_dist;
         int unsigned      slot;
         int               n;
         rsp_word_type     r;
         n = 0;
         if (w.kind == REQ_ISSUE) begin
            add_word(RSP_GRANT, next_issue, '0, '0);
            n = 1;
            next_issue = next_issue + 1;
         end else if (w.length != '0) begin
            tag_dist = w.tag - next_expected;
            if (tag_dist >= WIN) begin
               add_word(RSP_RANGE, w.tag, '0, '0);
               n = 1;
            end else if (tag_dist != '0) begin
               slot = w.tag % WIN;
               slot_valid[slot]   = 1'b1;
               slot_payload[slot] = w.payload;
               slot_length[slot]  = w.length;
            end else begin
               if (!suspend_mode) begin
                  add_word(RSP_DELIVER, w.tag, w.payload, w.length);
                  n++;
               end
               next_expected = next_expected + 1;
               slot = next_expected % WIN;
               while (slot_valid[slot]) begin
                  if (!suspend_mode && n < WIN) begin
                     add_word(RSP_DELIVER, next_expected, slot_payload[slot],
                              slot_length[slot]);
                     n++;
                  end
                  slot_valid[slot] = 1'b0;
                  next_expected = next_expected + 1;
                  slot = next_expected % WIN;
               end
            end
         end
         if (n > 0) begin
            r = expected_words[expected_words.size() - 1];
            r.last = 1'b1;
            expected_words[expected_words.size() - 1] = r;
         end
      endfunction

      function void check_delivery(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: kind %0d tag %h payload %h length %h last %b",
                        got.out_kind, got.tag_res, got.payload_res, got.length_res,
                        got.last);
            return;
         end
         want = expected_words.pop_front();
         if (got.out_kind !== want.out_kind || got.tag_res !== want.tag_res ||
             got.payload_res !== want.payload_res ||
             got.length_res !== want.length_res || got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected kind %0d tag %h payload %h length %h last %b",
                        want.out_kind, want.tag_res, want.payload_res, want.length_res,
                        want.last);
               $display("          got kind %0d tag %h payload %h length %h last %b",
                        got.out_kind, got.tag_res, got.payload_res, got.length_res,
                        got.last);
            end
         end
      endfunction

      function int pending_count();
         return expected_words.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_write_enable;
   logic         csr_write_data;

   delivery_scoreboard sb = new();
   int items_sent = 0;
   bit gaps_off = 1'b0;

   sequence_reorder_buffer #(.WINDOW(WIN)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_word         (req_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_delivery(rsp_word);
   end

   task automatic send_word(input req_word_type w);
      int gap;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      sb.accept_request(w);
      if (w.kind == REQ_ISSUE || w.length != '0)
         items_sent++;
      if (!gaps_off && $urandom_range(99) < 14) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_issue();
      req_word_type w;
      w.kind    = REQ_ISSUE;
      w.tag     = $urandom;
      w.payload = $urandom;
      w.length  = LENGTH_W'($urandom);
      send_word(w);
   endtask

   task automatic send_completion(input logic [TAG_W-1:0] tag,
                                  input logic [PAYLOAD_W-1:0] pay,
                                  input logic [LENGTH_W-1:0] len);
      req_word_type w;
      w.kind    = REQ_COMPLETE;
      w.tag     = tag;
      w.payload = pay;
      w.length  = len;
      send_word(w);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_suspend(input bit value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.suspend_mode = value;
   endtask

   // batch of tags completed out of order; optionally one tag held back
   task automatic run_batch(input bit hold_first);
      int               k;
      int               j;
      int               tmp;
      int               offs[16];
      logic [TAG_W-1:0] base;
      logic [TAG_W-1:0] tag;
      k = $urandom_range(16, 1);
      for (int i = 0; i < k; i++) begin
         offs[i] = i;
         send_issue();
      end
      for (int i = k - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         tmp = offs[i];
         offs[i] = offs[j];
         offs[j] = tmp;
      end
      base = sb.next_expected;
      for (int i = 0; i < k; i++) begin
         if (!(hold_first && offs[i] == 0)) begin
            tag = base + offs[i];
            send_completion(tag, $urandom, LENGTH_W'($urandom_range(65535, 1)));
            if (offs[i] != 0 && $urandom_range(9) == 0)
               send_completion(tag, $urandom, LENGTH_W'($urandom_range(65535, 1)));
         end
      end
   endtask

   task automatic run_random(input int count);
      int target;
      int pick;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70)
            run_batch(1'b0);
         else if (pick < 80)
            run_batch(1'b1);
         else if (pick < 84)
            send_completion(sb.next_expected + $urandom_range(1000, WIN), $urandom,
                            LENGTH_W'($urandom_range(65535, 1)));
         else if (pick < 88)
            send_completion(sb.next_expected - $urandom_range(100, 1), $urandom,
                            LENGTH_W'($urandom_range(65535, 1)));
         else if (pick < 92)
            send_completion($urandom, $urandom, LENGTH_W'($urandom_range(65535, 1)));
         else if (pick < 96)
            send_completion(sb.next_expected + $urandom_range(WIN - 1, 0), $urandom,
                            16'h0000);
         else
            send_issue();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_word         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_suspend(1'b0);

      send_issue();
      send_issue();
      send_completion(32'd0, 32'h0000_0000, 16'hFFFF);
      send_completion(32'd1, 32'hFFFF_FFFF, 16'h0000);
      send_completion(32'd2, 32'hA5A5_0002, 16'h0001);
      send_completion(32'd16, 32'h5A5A_0010, 16'h8000);
      send_completion(32'd17, 32'h1234_5678, 16'h0010);
      send_completion(32'hFFFF_FFFF, 32'h0BAD_0BAD, 16'h0020);
      send_completion(32'd0, 32'h0000_0001, 16'h0002);
      send_completion(32'd2, 32'hC3C3_0002, 16'h7FFF);
      send_completion(32'd1, 32'hFFFF_FFFF, 16'h0001);
      for (int t = 15; t >= 4; t--)
         send_completion(t, $urandom, LENGTH_W'($urandom_range(65535, 1)));
      send_completion(32'd3, 32'h0000_0003, 16'h0003);
      wait_idle();

      run_random(40);
      wait_idle();
      write_suspend(1'b1);
      run_random(25);
      wait_idle();
      write_suspend(1'b0);
      gaps_off = 1'b1;
      run_random(20);
      gaps_off = 1'b0;
      run_random(20);
      wait_idle();

      if (sb.failures == 0 && sb.pending_count() == 0)
         $display("sequence_reorder_buffer regression: pass");
      else
         $display("sequence_reorder_buffer regression: fail");
      $finish;
   end

   initial begin
      #600000;
      $display("sequence_reorder_buffer regression: fail");
      $finish;
   end

endmodule

// File: sequence_reorder_buffer.f
rtl/core/sro_pkg.sv
rtl/core/sro_ram.sv
rtl/core/sro_front.sv
rtl/core/sro_back.sv
rtl/core/sequence_reorder_buffer.sv
test/tb_top.sv
